// ===== rtl/sparse_matrix_add_sub_merge_macros.svh =====
// Assertion macros shared by the sparse matrix merge block.
`ifndef SPARSE_MATRIX_ADD_SUB_MERGE_MACROS_SVH
`define SPARSE_MATRIX_ADD_SUB_MERGE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SMASM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMASM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/smasm_pkg.sv =====
// Types and constants shared by the sparse matrix merge block.
`default_nettype none
package smasm_pkg;

    // Field widths of the item and result ports.
    localparam int OP_W     = 2;
    localparam int COORD_W  = 10;
    localparam int VALUE_W  = 32;
    localparam int RESULT_W = 33;

    // Operation codes of an input item.
    localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN      = 2'd2;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic append_a;
        logic append_b;
        logic run_start;
        logic step;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/smasm_ctrl.sv =====
// Controller state machine for the sparse matrix merge block.
`default_nettype none
module smasm_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [smasm_pkg::OP_W-1:0] i_operation,
    input  wire smasm_pkg::t_sts            i_sts,
    output smasm_pkg::t_cmd                 o_cmd,
    output logic                            o_busy
);
    import smasm_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands. Appends finish in the cycle they are taken.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_operation)
                        OP_APPEND_A: o_cmd.append_a = 1'b1;
                        OP_APPEND_B: o_cmd.append_b = 1'b1;
                        OP_RUN: begin
                            o_cmd.run_start = 1'b1;
                            n_state         = ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                if (i_sts.done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule
`default_nettype wire

// ===== rtl/smasm_datapath.sv =====
// Datapath of the sparse matrix merge block: list stores, merge step and result registers.
`default_nettype none
module smasm_datapath #(
    parameter int LIST_DEPTH = 32,
    parameter int CW         = 10
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire smasm_pkg::t_cmd                i_cmd,
    output smasm_pkg::t_sts                     o_sts,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic                           i_cfg_wr_data,
    input  wire logic [smasm_pkg::COORD_W-1:0]  i_row,
    input  wire logic [smasm_pkg::COORD_W-1:0]  i_column,
    input  wire logic signed [smasm_pkg::VALUE_W-1:0] i_value,
    output logic                                o_result_valid,
    output logic [smasm_pkg::COORD_W-1:0]       o_out_row,
    output logic [smasm_pkg::COORD_W-1:0]       o_out_column,
    output logic signed [smasm_pkg::RESULT_W-1:0] o_out_value,
    output logic                                o_is_empty,
    output logic                                o_is_last
);
    import smasm_pkg::*;

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int ENT_W = 2 * CW + VALUE_W;

    // List stores, one write port and one registered read port each.
    logic [ENT_W-1:0] mem_a [LIST_DEPTH];
    logic [ENT_W-1:0] mem_b [LIST_DEPTH];
    logic [ENT_W-1:0] r_rd_a;
    logic [ENT_W-1:0] r_rd_b;

    logic [CNT_W-1:0] r_cnt_a, r_cnt_b;
    logic [CNT_W-1:0] r_i, r_j, n_i, n_j;
    logic             r_sub;

    // Held-back result, so that the final one can carry the last flag.
    logic                      r_pend_valid;
    logic [CW-1:0]             r_pend_row, r_pend_col;
    logic signed [RESULT_W-1:0] r_pend_val;

    logic                      r_out_valid, r_out_empty, r_out_last;
    logic [CW-1:0]             r_out_row, r_out_col;
    logic signed [RESULT_W-1:0] r_out_val;

    logic [ENT_W-1:0]          wr_entry;
    logic                      a_more, b_more, a_full, b_full;
    logic [CW-1:0]             a_row, a_col, b_row, b_col;
    logic signed [RESULT_W-1:0] a_val, b_val, b_signed, sum;
    logic                      same, a_first;
    logic                      adv_a, adv_b, emit;
    logic [CW-1:0]             e_row, e_col;
    logic signed [RESULT_W-1:0] e_val;

    assign wr_entry = {i_row[CW-1:0], i_column[CW-1:0], i_value};
    assign a_full   = (r_cnt_a >= CNT_W'(LIST_DEPTH));
    assign b_full   = (r_cnt_b >= CNT_W'(LIST_DEPTH));
    assign a_more   = (r_i < r_cnt_a);
    assign b_more   = (r_j < r_cnt_b);
    assign o_sts.done = !a_more && !b_more;

    // Unpack the list heads.
    assign a_row = r_rd_a[ENT_W-1 -: CW];
    assign a_col = r_rd_a[VALUE_W +: CW];
    assign a_val = RESULT_W'(signed'(r_rd_a[VALUE_W-1:0]));
    assign b_row = r_rd_b[ENT_W-1 -: CW];
    assign b_col = r_rd_b[VALUE_W +: CW];
    assign b_val = RESULT_W'(signed'(r_rd_b[VALUE_W-1:0]));

    // One merge step: compare heads in row-major order and pick the result.
    always_comb begin
        same     = ({a_row, a_col} == {b_row, b_col});
        a_first  = ({a_row, a_col} < {b_row, b_col});
        b_signed = r_sub ? -b_val : b_val;
        sum      = a_val + b_signed;
        adv_a    = 1'b0;
        adv_b    = 1'b0;
        emit     = 1'b0;
        e_row    = a_row;
        e_col    = a_col;
        e_val    = a_val;
        if (a_more && b_more) begin
            if (same) begin
                adv_a = 1'b1;
                adv_b = 1'b1;
                emit  = (sum != '0);
                e_val = sum;
            end else if (a_first) begin
                adv_a = 1'b1;
                emit  = 1'b1;
            end else begin
                adv_b = 1'b1;
                emit  = 1'b1;
                e_row = b_row;
                e_col = b_col;
                e_val = b_signed;
            end
        end else if (a_more) begin
            adv_a = 1'b1;
            emit  = 1'b1;
        end else if (b_more) begin
            adv_b = 1'b1;
            emit  = 1'b1;
            e_row = b_row;
            e_col = b_col;
            e_val = b_signed;
        end
    end

    // Next read indexes; the stores read at these so heads track r_i and r_j.
    always_comb begin
        n_i = r_i;
        n_j = r_j;
        if (i_cmd.run_start) begin
            n_i = '0;
            n_j = '0;
        end else if (i_cmd.step) begin
            if (adv_a) n_i = r_i + CNT_W'(1);
            if (adv_b) n_j = r_j + CNT_W'(1);
        end
    end

    // Store writes and reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append_a && !a_full) begin
            mem_a[r_cnt_a[IDX_W-1:0]] <= wr_entry;
        end
        r_rd_a <= mem_a[n_i[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append_b && !b_full) begin
            mem_b[r_cnt_b[IDX_W-1:0]] <= wr_entry;
        end
        r_rd_b <= mem_b[n_j[IDX_W-1:0]];
    end

    // Control registers: counts, indexes, mode, and valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_sub        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= i_cmd.finish || (i_cmd.step && emit && r_pend_valid);
            if (i_cfg_wr_en) r_sub <= i_cfg_wr_data;
            if (i_cmd.append_a && !a_full) r_cnt_a <= r_cnt_a + CNT_W'(1);
            if (i_cmd.append_b && !b_full) r_cnt_b <= r_cnt_b + CNT_W'(1);
            if (i_cmd.run_start) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.step && emit) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    // Result payload: pass on the held result and hold the new one.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && emit) begin
            r_pend_row  <= e_row;
            r_pend_col  <= e_col;
            r_pend_val  <= e_val;
            r_out_row   <= r_pend_row;
            r_out_col   <= r_pend_col;
            r_out_val   <= r_pend_val;
            r_out_empty <= 1'b0;
            r_out_last  <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_last <= 1'b1;
            if (r_pend_valid) begin
                r_out_row   <= r_pend_row;
                r_out_col   <= r_pend_col;
                r_out_val   <= r_pend_val;
                r_out_empty <= 1'b0;
            end else begin
                r_out_row   <= '0;
                r_out_col   <= '0;
                r_out_val   <= '0;
                r_out_empty <= 1'b1;
            end
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_out_row      = COORD_W'(r_out_row);
    assign o_out_column   = COORD_W'(r_out_col);
    assign o_out_value    = r_out_val;
    assign o_is_empty     = r_out_empty;
    assign o_is_last      = r_out_last;

endmodule
`default_nettype wire

// ===== rtl/sparse_matrix_add_sub_merge.sv =====
// Top level of the sparse matrix add/subtract coordinate-list merge block.
// Usage: an append item (start with operation 0 or 1) stores one entry, or is
// dropped if its list is full, and busy stays low, so appends can follow every
// cycle. A run item raises busy; the block fetches the list heads, then runs
// the merge steps (a step consumes one entry of either list or one of each),
// then flushes. Each result is held back until the next one or the flush, so
// results leave one per cycle at most, each on the outputs for exactly one
// cycle with o_result_valid; the receiver cannot stall, so it must take every transfer.
// The last transfer of a run carries o_is_last and busy is already low then.
// No clearing pass follows reset; subtract mode may be written while idle.
`default_nettype none
module sparse_matrix_add_sub_merge #(
    parameter int LIST_DEPTH = 32,
    parameter int COORD_BITS = 10
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic [smasm_pkg::OP_W-1:0]             i_operation,
    input  wire logic [smasm_pkg::COORD_W-1:0]          i_row,
    input  wire logic [smasm_pkg::COORD_W-1:0]          i_column,
    input  wire logic signed [smasm_pkg::VALUE_W-1:0]   i_value,
    input  wire logic                                   i_cfg_wr_en,
    input  wire logic                                   i_cfg_wr_data,
    output logic                                        o_result_valid,
    output logic [smasm_pkg::COORD_W-1:0]               o_out_row,
    output logic [smasm_pkg::COORD_W-1:0]               o_out_column,
    output logic signed [smasm_pkg::RESULT_W-1:0]       o_out_value,
    output logic                                        o_is_empty,
    output logic                                        o_is_last
);
    import smasm_pkg::*;

`include "sparse_matrix_add_sub_merge_macros.svh"

    // Stored coordinate width: only the low CW bits (COORD_BITS, capped at COORD_W) of a port are kept.
    localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;

    t_cmd cmd;
    t_sts sts;

    // Controller.
    smasm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    // Datapath.
    smasm_datapath #(
        .LIST_DEPTH (LIST_DEPTH),
        .CW         (CW)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_row          (i_row),
        .i_column       (i_column),
        .i_value        (i_value),
        .o_result_valid (o_result_valid),
        .o_out_row      (o_out_row),
        .o_out_column   (o_out_column),
        .o_out_value    (o_out_value),
        .o_is_empty     (o_is_empty),
        .o_is_last      (o_is_last)
    );

    // An empty marker ends its run and carries zero fields.
    `SMASM_ASSERT_NOW(a_empty_is_last, i_clk, i_rst_n, o_result_valid && o_is_empty, o_is_last && (o_out_value == '0) && (o_out_row == '0) && (o_out_column == '0), "empty marker malformed")
    // The final transfer of a run is delivered after the controller is idle.
    `SMASM_ASSERT_NOW(a_last_when_idle, i_clk, i_rst_n, o_result_valid && o_is_last, !busy, "last result while busy")
    // An accepted run always occupies the block in the next cycle.
    `SMASM_ASSERT_NEXT(a_run_busy, i_clk, i_rst_n, start && !busy && (i_operation == OP_RUN), busy, "run not started")

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the sparse matrix add/subtract coordinate-list merge block.
module tb;
    import smasm_pkg::*;

    localparam int LIST_DEPTH     = 32;
    localparam int POOL_SIZE      = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 76;

    // Operation code that the block must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Settings of the subtract mode register.
    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_SUB = 1'b1;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        column;
        logic signed [VALUE_W-1:0] value;
    } t_list_entry;

    typedef struct packed {
        logic [COORD_W-1:0]         row;
        logic [COORD_W-1:0]         column;
        logic signed [RESULT_W-1:0] value;
        logic                       is_empty;
        logic                       is_last;
    } t_merged_entry;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [OP_W-1:0]             i_operation;
    logic [COORD_W-1:0]          i_row;
    logic [COORD_W-1:0]          i_column;
    logic signed [VALUE_W-1:0]   i_value;
    logic                        i_cfg_wr_en;
    logic                        i_cfg_wr_data;
    logic                        o_result_valid;
    logic [COORD_W-1:0]          o_out_row;
    logic [COORD_W-1:0]          o_out_column;
    logic signed [RESULT_W-1:0]  o_out_value;
    logic                        o_is_empty;
    logic                        o_is_last;

    // Shadow copy of the two coordinate lists and the mode register.
    t_list_entry   first_list [LIST_DEPTH];
    t_list_entry   second_list[LIST_DEPTH];
    int            first_count;
    int            second_count;
    logic          subtract_mode;

    // Merged entries still to come out of the block, oldest first.
    t_merged_entry pending_results[$];

    int            mismatch_count;
    int            stall_cycles;
    int            sender_idle_pct;

    // Sorted coordinate pool that the random appends walk through.
    logic [2*COORD_W-1:0]      coord_pool [POOL_SIZE];
    logic signed [VALUE_W-1:0] first_vals [POOL_SIZE];
    logic signed [VALUE_W-1:0] second_vals[POOL_SIZE];
    bit                        first_used [POOL_SIZE];
    bit                        second_used[POOL_SIZE];
    int                        first_cursor;
    int                        second_cursor;

    sparse_matrix_add_sub_merge u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_row          (i_row),
        .i_column       (i_column),
        .i_value        (i_value),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_result_valid (o_result_valid),
        .o_out_row      (o_out_row),
        .o_out_column   (o_out_column),
        .o_out_value    (o_out_value),
        .o_is_empty     (o_is_empty),
        .o_is_last      (o_is_last)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_merged_entry make_result(input logic [COORD_W-1:0] row,
                                                  input logic [COORD_W-1:0] column,
                                                  input logic signed [RESULT_W-1:0] value,
                                                  input logic is_empty);
        t_merged_entry res;
        res.row      = row;
        res.column   = column;
        res.value    = value;
        res.is_empty = is_empty;
        res.is_last  = 1'b0;
        return res;
    endfunction

    // Walk both lists in row-major order and queue the merged entries of one run.
    function automatic void predict_merge();
        t_merged_entry              run_out[2*LIST_DEPTH];
        int                         i;
        int                         j;
        int                         n;
        bit                         take_first;
        bit                         take_second;
        logic signed [RESULT_W-1:0] first_val;
        logic signed [RESULT_W-1:0] second_val;
        logic signed [RESULT_W-1:0] total;
        i = 0;
        j = 0;
        n = 0;
        while (i < first_count || j < second_count) begin
            take_first  = 1'b0;
            take_second = 1'b0;
            if (i < first_count && j < second_count) begin
                if (first_list[i].row == second_list[j].row &&
                    first_list[i].column == second_list[j].column) begin
                    take_first  = 1'b1;
                    take_second = 1'b1;
                end else if ({first_list[i].row, first_list[i].column} <
                             {second_list[j].row, second_list[j].column}) begin
                    take_first = 1'b1;
                end else begin
                    take_second = 1'b1;
                end
            end else if (i < first_count) begin
                take_first = 1'b1;
            end else begin
                take_second = 1'b1;
            end
            first_val  = '0;
            second_val = '0;
            if (take_first)
                first_val = first_list[i].value;
            if (take_second)
                second_val = subtract_mode ? -RESULT_W'(second_list[j].value)
                                           : RESULT_W'(second_list[j].value);
            if (take_first && take_second) begin
                // Coinciding coordinates combine; a zero outcome is dropped.
                total = first_val + second_val;
                if (total != 0) begin
                    run_out[n] = make_result(first_list[i].row, first_list[i].column,
                                             total, 1'b0);
                    n++;
                end
                i++;
                j++;
            end else if (take_first) begin
                run_out[n] = make_result(first_list[i].row, first_list[i].column,
                                         first_val, 1'b0);
                n++;
                i++;
            end else begin
                run_out[n] = make_result(second_list[j].row, second_list[j].column,
                                         second_val, 1'b0);
                n++;
                j++;
            end
        end
        // A run without entries gives a single empty marker.
        if (n == 0) begin
            run_out[0] = make_result('0, '0, '0, 1'b1);
            n = 1;
        end
        run_out[n-1].is_last = 1'b1;
        for (int k = 0; k < n; k++)
            pending_results.push_back(run_out[k]);
    endfunction

    // Update the shadow state for one accepted item.
    function automatic void predict_item(input logic [OP_W-1:0] op,
                                         input logic [COORD_W-1:0] row,
                                         input logic [COORD_W-1:0] column,
                                         input logic signed [VALUE_W-1:0] value);
        t_list_entry ent;
        ent.row    = row;
        ent.column = column;
        ent.value  = value;
        if (op == OP_APPEND_A) begin
            if (first_count < LIST_DEPTH) begin
                first_list[first_count] = ent;
                first_count++;
            end
        end else if (op == OP_APPEND_B) begin
            if (second_count < LIST_DEPTH) begin
                second_list[second_count] = ent;
                second_count++;
            end
        end else if (op == OP_RUN) begin
            predict_merge();
        end
    endfunction

    // Present one item, optionally after idle cycles, and hold it until the transfer.
    task automatic send_item(input logic [OP_W-1:0] op,
                             input logic [COORD_W-1:0] row,
                             input logic [COORD_W-1:0] column,
                             input logic signed [VALUE_W-1:0] value);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start       = 1'b1;
        i_operation = op;
        i_row       = row;
        i_column    = column;
        i_value     = value;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_item(op, row, column, value);
    endtask

    // Drop start and wait until every queued entry has come out.
    task automatic wait_until_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_subtract_mode(input logic mode);
        wait_until_drained();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = mode;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        subtract_mode = mode;
    endtask

    function automatic logic signed [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return '0;
            3:       return 32'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom();
        endcase
    endfunction

    // Append in coordinate order from the shared pool, often hitting the other
    // list's coordinate with a value that cancels in one of the two modes.
    task automatic send_random_append(input bit to_second);
        logic [OP_W-1:0]           op;
        int                        filled;
        int                        idx;
        int                        pick;
        bit                        partner_used;
        logic signed [VALUE_W-1:0] partner_val;
        logic signed [VALUE_W-1:0] val;
        op     = to_second ? OP_APPEND_B : OP_APPEND_A;
        filled = to_second ? second_count : first_count;
        if (filled >= LIST_DEPTH) begin
            // The list is full, so this transfer is dropped by the block.
            send_item(op, COORD_W'($urandom), COORD_W'($urandom), $urandom);
        end else begin
            if (filled == LIST_DEPTH - 1) begin
                idx = POOL_SIZE - 1;
            end else begin
                idx = (to_second ? second_cursor : first_cursor) + int'($urandom_range(1, 2));
                if (idx > POOL_SIZE - 2)
                    idx = POOL_SIZE - 2;
            end
            partner_used = to_second ? first_used[idx] : second_used[idx];
            partner_val  = to_second ? first_vals[idx] : second_vals[idx];
            pick         = $urandom_range(0, 2);
            val          = random_value();
            if (partner_used && pick == 0)
                val = partner_val;
            else if (partner_used && pick == 1)
                val = -partner_val;
            if (to_second) begin
                second_used[idx] = 1'b1;
                second_vals[idx] = val;
                second_cursor    = idx;
            end else begin
                first_used[idx] = 1'b1;
                first_vals[idx] = val;
                first_cursor    = idx;
            end
            send_item(op, coord_pool[idx][2*COORD_W-1:COORD_W], coord_pool[idx][COORD_W-1:0],
                      val);
        end
    endtask

    // A run on two empty lists.
    task automatic test_empty_run();
        send_item(OP_RUN, '0, '0, '0);
    endtask

    // One entry passes through alone.
    task automatic test_single_entry();
        send_item(OP_APPEND_A, '0, '0, VALUE_MIN);
        send_item(OP_RUN, '0, '0, '0);
    endtask

    // Equal entries cancel in subtract mode and double in add mode.
    task automatic test_full_cancellation();
        write_subtract_mode(MODE_SUB);
        send_item(OP_APPEND_B, '0, '0, VALUE_MIN);
        send_item(OP_RUN, '0, '0, '0);
        write_subtract_mode(MODE_ADD);
        send_item(OP_RUN, '0, '0, '0);
    endtask

    // Extreme values, zero values and entries found in one list only, both modes.
    task automatic test_extreme_values();
        send_item(OP_APPEND_A, 10'd0, 10'd1, VALUE_MAX);
        send_item(OP_APPEND_B, 10'd0, 10'd1, VALUE_MAX);
        send_item(OP_APPEND_B, 10'd0, 10'd2, VALUE_MIN);
        send_item(OP_APPEND_A, 10'd0, 10'd4, '0);
        send_item(OP_APPEND_A, 10'd0, 10'd7, 32'sd5);
        send_item(OP_APPEND_B, 10'd0, 10'd7, 32'sd5);
        send_item(OP_RUN, '0, '0, '0);
        write_subtract_mode(MODE_SUB);
        send_item(OP_RUN, '0, '0, '0);
    endtask

    // An entry out of coordinate order and an unused operation code.
    task automatic test_unsorted_and_unused();
        send_item(OP_APPEND_A, 10'd0, 10'd3, -32'sd1);
        send_item(OP_UNUSED, 10'd1023, 10'd1023, -32'sd1);
        send_item(OP_RUN, 10'd1023, 10'd1023, VALUE_MAX);
        write_subtract_mode(MODE_ADD);
        send_item(OP_RUN, '0, '0, '0);
    endtask

    // Random appends and runs over several pacing phases and both modes.
    task automatic test_random_merge();
        int                   phase_idle[6] = '{0, 67, 7, 0, 67, 7};
        logic                 phase_mode[6] = '{MODE_ADD, MODE_SUB, MODE_ADD,
                                                MODE_SUB, MODE_SUB, MODE_ADD};
        logic [2*COORD_W-1:0] coord;
        int                   roll;
        // Strictly increasing coordinates starting at row one, last one at the corner.
        coord = 20'd1024;
        for (int k = 0; k < POOL_SIZE - 1; k++) begin
            coord_pool[k]  = coord;
            first_used[k]  = 1'b0;
            second_used[k] = 1'b0;
            coord          = coord + 20'($urandom_range(1, 16000));
        end
        coord_pool[POOL_SIZE-1]  = '1;
        first_used[POOL_SIZE-1]  = 1'b0;
        second_used[POOL_SIZE-1] = 1'b0;
        first_cursor  = -1;
        second_cursor = -1;
        for (int p = 0; p < 6; p++) begin
            write_subtract_mode(phase_mode[p]);
            sender_idle_pct = phase_idle[p];
            repeat (PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    send_item(OP_UNUSED, COORD_W'($urandom), COORD_W'($urandom), $urandom);
                else if (roll < 22)
                    send_random_append($urandom_range(0, 1));
                else
                    send_item(OP_RUN, COORD_W'($urandom), COORD_W'($urandom), $urandom);
            end
        end
        sender_idle_pct = 0;
    endtask

    // Compare every result transfer with the oldest expected entry.
    always @(posedge i_clk) begin : result_check
        t_merged_entry want;
        t_merged_entry got;
        if (i_rst_n && o_result_valid) begin
            got.row      = o_out_row;
            got.column   = o_out_column;
            got.value    = o_out_value;
            got.is_empty = o_is_empty;
            got.is_last  = o_is_last;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: row %0d col %0d value %0d empty %0b last %0b",
                             got.row, got.column, got.value, got.is_empty, got.is_last);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch: expected row %0d col %0d value %0d empty %0b last %0b",
                                 want.row, want.column, want.value, want.is_empty,
                                 want.is_last);
                        $display("          got row %0d col %0d value %0d empty %0b last %0b",
                                 got.row, got.column, got.value, got.is_empty, got.is_last);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Reset, then the test sequence and the final verdict.
    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_operation     = OP_APPEND_A;
        i_row           = '0;
        i_column        = '0;
        i_value         = '0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = MODE_ADD;
        subtract_mode   = MODE_ADD;
        first_count     = 0;
        second_count    = 0;
        mismatch_count  = 0;
        stall_cycles    = 0;
        sender_idle_pct = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_run();
        test_single_entry();
        test_full_cancellation();
        test_extreme_values();
        test_unsorted_and_unused();
        test_random_merge();

        wait_until_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
